// ===== src/mf3_pkg.sv =====
// Shared constants, types and helper function of the 3x3 median filter.
package mf3_pkg;

  // Store depth and the widths that follow from it.
  localparam int MAX_LINE = 2048;
  localparam int BIN_W    = $clog2(MAX_LINE);
  localparam int LEN_W    = $clog2(MAX_LINE + 1);

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int LINE_W   = 16;
  localparam int CFG_W    = 12;
  localparam int TAPS     = 9;
  localparam int TAP_W    = $clog2(TAPS);

  // Shortest line that still has an interior bin, and the line length after reset.
  localparam int MIN_LINE   = 3;
  localparam int RESET_LINE = 1025;

  // Lines completed since frame start, saturating once the window is full.
  localparam logic [1:0] LINES_FULL = 2'd2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [TAP_W-1:0]    tap_t;
  typedef logic [TAPS-1:0][SAMPLE_W-1:0] win_t;

  typedef struct packed {
    sample_t sample;
    logic    frame_start;
  } in_word_t;

  typedef struct packed {
    logic [BIN_W-1:0]  bin_index;
    logic [LINE_W-1:0] line_index;
    sample_t           median_value;
  } out_word_t;

  // Position of the window centre, carried alongside the taps.
  typedef struct packed {
    logic [BIN_W-1:0]  bin;
    logic [LINE_W-1:0] line;
  } tag_t;

  typedef struct packed {
    win_t taps;
    tag_t tag;
  } window_t;

  // Clamp a written line length into the range the line store supports.
  function automatic logic [LEN_W-1:0] clamp_len(logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (32'(v) < MIN_LINE) begin
      r = LEN_W'(MIN_LINE);
    end else if (32'(v) > MAX_LINE) begin
      r = LEN_W'(MAX_LINE);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== src/mf3_in_if.sv =====
// Sample channel: valid, ready and one input word.
interface mf3_in_if;
  import mf3_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// ===== src/mf3_out_if.sv =====
// Result channel: valid, ready and one filtered word.
interface mf3_out_if;
  import mf3_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// ===== src/median_filter_3x3_top.sv =====
// Top level of the streaming 3x3 spectrogram median filter.
//
// Takes one magnitude word per clock cycle and returns, for each word that
// completes a window, the median of the 3x3 neighbourhood with the bin and
// line of its centre; border bins and the first and last line give no word.
// The rate of one word a cycle is set by the line store, one memory with a
// write and a read port that is read and rewritten once per word; the median
// network is fully pipelined behind it. A stall on the result side holds the
// pipeline but lets words enter while stages are empty. The user must write the
// line length through cfg_write and cfg_data only while the block is idle;
// not enforced by the block, which clamps the length to 3 to the store depth.
module median_filter_3x3_top (
  input  logic                      clk,
  input  logic                      rst,
  mf3_in_if.sink                    pixels,
  mf3_out_if.source                 medians,
  input  logic                      cfg_write,
  input  logic [mf3_pkg::CFG_W-1:0] cfg_data
);
  import mf3_pkg::*;

  logic [LEN_W-1:0] len;
  logic             win_valid;
  logic             win_ready;
  window_t          win;

  // Line length register, held already clamped.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= clamp_len(CFG_W'(RESET_LINE));
    end else if (cfg_write) begin
      len <= clamp_len(cfg_data);
    end
  end

  mf3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .len       (len),
    .pixels    (pixels),
    .win_valid (win_valid),
    .win       (win),
    .win_ready (win_ready)
  );

  mf3_median u_median (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .win       (win),
    .win_ready (win_ready),
    .medians   (medians)
  );

endmodule

// ===== src/mf3_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mf3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mf3_front.sv =====
// Position counters, two-line store and window columns that build the 3x3 window.
module mf3_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [mf3_pkg::LEN_W-1:0] len,
  mf3_in_if.sink                   pixels,
  output logic                     win_valid,
  output mf3_pkg::window_t         win,
  input  logic                     win_ready
);
  import mf3_pkg::*;

  // Position state.
  logic [BIN_W-1:0]  bin_cnt;
  logic [LINE_W-1:0] line_cnt;
  logic [1:0]        lines_seen;

  // Stage A: store read in flight.
  logic              a_valid;
  logic [BIN_W-1:0]  a_bin;
  sample_t           a_sample;
  logic              a_emit;
  tag_t              a_tag;
  logic              byp;
  logic [2*SAMPLE_W-1:0] byp_data;

  // Window columns b-2 and b-1 of the older, previous and current rows.
  sample_t           col [6];

  logic en_a, en_b, accept, collide;
  logic [2*SAMPLE_W-1:0] ram_rdata, rd, wdata;
  sample_t           rd_older, rd_prev;

  logic [BIN_W-1:0]  bc0, b;
  logic [LINE_W-1:0] lc0, lc1;
  logic [1:0]        ls0, ls1;
  logic              pre_close, post_close, emit;
  logic [LEN_W-1:0]  nb;
  logic [BIN_W-1:0]  bin_cnt_next;
  logic [LINE_W-1:0] line_cnt_next;
  logic [1:0]        lines_seen_next;

  // Stall chain: a stage moves when it is empty or the next one moves.
  assign en_b         = !win_valid || win_ready;
  assign en_a         = !a_valid || en_b;
  assign pixels.ready = en_a;
  assign accept       = pixels.valid && en_a;

  // Work out the bin of the arriving word, closing a line before and after it.
  always_comb begin
    bc0 = pixels.data.frame_start ? '0 : bin_cnt;
    lc0 = pixels.data.frame_start ? '0 : line_cnt;
    ls0 = pixels.data.frame_start ? '0 : lines_seen;

    pre_close = LEN_W'(bc0) >= len;
    b   = pre_close ? '0 : bc0;
    lc1 = pre_close ? lc0 + LINE_W'(1) : lc0;
    ls1 = (pre_close && ls0 != LINES_FULL) ? ls0 + 2'd1 : ls0;

    emit = (ls1 == LINES_FULL) && (b >= BIN_W'(2));

    nb              = LEN_W'(b) + LEN_W'(1);
    post_close      = nb >= len;
    bin_cnt_next    = post_close ? '0 : nb[BIN_W-1:0];
    line_cnt_next   = post_close ? lc1 + LINE_W'(1) : lc1;
    lines_seen_next = (post_close && ls1 != LINES_FULL) ? ls1 + 2'd1 : ls1;
  end

  // Counter registers advance once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_cnt    <= '0;
      line_cnt   <= '0;
      lines_seen <= '0;
    end else if (accept) begin
      bin_cnt    <= bin_cnt_next;
      line_cnt   <= line_cnt_next;
      lines_seen <= lines_seen_next;
    end
  end

  // One entry per bin holds the older row in the upper half and the previous row below.
  assign rd       = byp ? byp_data : ram_rdata;
  assign rd_older = rd[2*SAMPLE_W-1:SAMPLE_W];
  assign rd_prev  = rd[SAMPLE_W-1:0];
  assign wdata    = {rd_prev, a_sample};

  // A read of the bin written at the same edge takes the word being written.
  assign collide = accept && a_valid && en_b && (b == a_bin);

  mf3_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (MAX_LINE)
  ) u_store (
    .clk   (clk),
    .we    (a_valid && en_b),
    .waddr (a_bin),
    .wdata (wdata),
    .re    (accept),
    .raddr (b),
    .rdata (ram_rdata)
  );

  // Stage A control.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      byp     <= 1'b0;
    end else if (en_a) begin
      a_valid <= pixels.valid;
      if (accept) begin
        byp <= collide;
      end
    end
  end

  // Stage A payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_bin    <= b;
      a_sample <= pixels.data.sample;
      a_emit   <= emit;
      a_tag    <= '{bin: b - BIN_W'(1), line: lc1 - LINE_W'(1)};
      byp_data <= wdata;
    end
  end

  // Window columns shift once per word leaving stage A.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        col[i] <= '0;
      end
    end else if (a_valid && en_b) begin
      col[0] <= col[1];
      col[1] <= rd_older;
      col[2] <= col[3];
      col[3] <= rd_prev;
      col[4] <= col[5];
      col[5] <= a_sample;
    end
  end

  // Stage B: only interior positions go on to the median network.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (en_b) begin
      win_valid <= a_valid && a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && en_b) begin
      win.taps <= {a_sample, col[5], col[4], rd_prev, col[3], col[2],
                   rd_older, col[1], col[0]};
      win.tag  <= a_tag;
    end
  end

endmodule

// ===== src/mf3_median.sv =====
// Pipelined compare-exchange network that selects the median of nine taps.
module mf3_median (
  input  logic             clk,
  input  logic             rst,
  input  logic             win_valid,
  input  mf3_pkg::window_t win,
  output logic             win_ready,
  mf3_out_if.source        medians
);
  import mf3_pkg::*;

  // Order one pair so that the first named tap holds the smaller value.
  function automatic win_t cs(win_t w, tap_t i, tap_t j);
    win_t    r;
    sample_t x;
    r = w;
    if (r[i] > r[j]) begin
      x    = r[i];
      r[i] = r[j];
      r[j] = x;
    end
    return r;
  endfunction

  logic    v1, v2, v3;
  window_t r1, r2, r3;
  win_t    n1, n2, n3, n4;
  logic    en1, en2, en3, en4;

  assign en4       = !medians.valid || medians.ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign win_ready = en1;

  // Exchange layers, split into four groups of about equal depth.
  always_comb begin
    n1 = win.taps;
    n1 = cs(n1, 4'd1, 4'd2);
    n1 = cs(n1, 4'd4, 4'd5);
    n1 = cs(n1, 4'd7, 4'd8);
    n1 = cs(n1, 4'd0, 4'd1);
    n1 = cs(n1, 4'd3, 4'd4);
    n1 = cs(n1, 4'd6, 4'd7);

    n2 = r1.taps;
    n2 = cs(n2, 4'd1, 4'd2);
    n2 = cs(n2, 4'd4, 4'd5);
    n2 = cs(n2, 4'd7, 4'd8);
    n2 = cs(n2, 4'd0, 4'd3);
    n2 = cs(n2, 4'd5, 4'd8);
    n2 = cs(n2, 4'd4, 4'd7);

    n3 = r2.taps;
    n3 = cs(n3, 4'd3, 4'd6);
    n3 = cs(n3, 4'd1, 4'd4);
    n3 = cs(n3, 4'd2, 4'd5);
    n3 = cs(n3, 4'd4, 4'd7);

    n4 = r3.taps;
    n4 = cs(n4, 4'd4, 4'd2);
    n4 = cs(n4, 4'd6, 4'd4);
    n4 = cs(n4, 4'd4, 4'd2);
  end

  // Valid bits travel with the taps.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      medians.valid <= 1'b0;
    end else begin
      if (en1) v1 <= win_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) medians.valid <= v3;
    end
  end

  // Stage payloads; the output register is the last stage.
  always_ff @(posedge clk) begin
    if (en1 && win_valid) begin
      r1 <= '{taps: n1, tag: win.tag};
    end
    if (en2 && v1) begin
      r2 <= '{taps: n2, tag: r1.tag};
    end
    if (en3 && v2) begin
      r3 <= '{taps: n3, tag: r2.tag};
    end
    if (en4 && v3) begin
      medians.data <= '{bin_index: r3.tag.bin, line_index: r3.tag.line,
                        median_value: n4[4]};
    end
  end

endmodule

// ===== src/mf3_checker.sv =====
// Port-level checks of the median filter, bound to the top level.
module mf3_checker (
  input  logic                      clk,
  input  logic                      rst,
  mf3_in_if.sink                    pixels,
  mf3_out_if.source                 medians,
  input  logic                      cfg_write,
  input  logic [mf3_pkg::CFG_W-1:0] cfg_data
);
  import mf3_pkg::*;

  logic [LEN_W-1:0] len;

  // Mirror of the line length in use.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= clamp_len(CFG_W'(RESET_LINE));
    end else if (cfg_write) begin
      len <= clamp_len(cfg_data);
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !medians.valid)
    else $error("result word shown straight after reset");

  // A waiting result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    medians.valid && !medians.ready |=> medians.valid && $stable(medians.data))
    else $error("result word changed or dropped while stalled");

  // Only interior bins are emitted.
  a_interior: assert property (@(posedge clk) disable iff (rst)
    medians.valid |-> medians.data.bin_index != '0 &&
                      (LEN_W'(medians.data.bin_index) + LEN_W'(1)) < len)
    else $error("border bin emitted");

  // With the result side free, the whole pipeline can move and the input is ready.
  a_ready_path: assert property (@(posedge clk) disable iff (rst)
    medians.ready |-> pixels.ready)
    else $error("input stalled while result side was free");

endmodule

bind median_filter_3x3_top mf3_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .pixels    (pixels),
  .medians   (medians),
  .cfg_write (cfg_write),
  .cfg_data  (cfg_data)
);

// ===== tb/mf3_tb_pkg.sv =====
// Tracker class that predicts and checks the median words of the 3x3 filter.
`timescale 1ns / 100ps
package mf3_tb_pkg;
  import mf3_pkg::*;

  class median_tracker;
    sample_t           previous_line [MAX_LINE];
    sample_t           older_line [MAX_LINE];
    sample_t           cols [6];
    int                bin_pos;
    logic [LINE_W-1:0] line_pos;
    int                full_lines;
    logic [CFG_W-1:0]  line_len;
    out_word_t         expected_medians [$];
    int                mismatches;

    // State after reset; the line stores start cleared.
    function new();
      int i;
      for (i = 0; i < MAX_LINE; i++) begin
        previous_line[i] = '0;
        older_line[i]    = '0;
      end
      for (i = 0; i < 6; i++) begin
        cols[i] = '0;
      end
      bin_pos    = 0;
      line_pos   = '0;
      full_lines = 0;
      line_len   = CFG_W'(RESET_LINE);
      mismatches = 0;
    endfunction

    function void set_length(logic [CFG_W-1:0] v);
      line_len = v;
    endfunction

    // The written length, limited to the range the store can hold.
    function int active_length();
      int n;
      n = int'(line_len);
      if (n < MIN_LINE) n = MIN_LINE;
      if (n > MAX_LINE) n = MAX_LINE;
      return n;
    endfunction

    function void next_line();
      bin_pos  = 0;
      line_pos = line_pos + 1'b1;
      if (full_lines < 2) full_lines++;
    endfunction

    // The median is the value with at most four smaller and at least five not larger.
    function sample_t median9(sample_t v [9]);
      int      i;
      int      j;
      int      lo;
      int      le;
      sample_t r;
      r = v[0];
      for (i = 0; i < 9; i++) begin
        lo = 0;
        le = 0;
        for (j = 0; j < 9; j++) begin
          if (v[j] < v[i]) lo++;
          if (v[j] <= v[i]) le++;
        end
        if (lo <= 4 && le >= 5) r = v[i];
      end
      return r;
    endfunction

    // Advance the window by one accepted sample word and queue any median it completes.
    function void take_sample(sample_t s, logic fs);
      int        len;
      int        b;
      sample_t   o;
      sample_t   p;
      sample_t   win [9];
      out_word_t w;
      if (fs) begin
        bin_pos    = 0;
        line_pos   = '0;
        full_lines = 0;
      end
      len = active_length();
      // A shortened length closes the current line before this sample.
      if (bin_pos >= len) next_line();
      b = bin_pos;
      o = older_line[b];
      p = previous_line[b];
      if (full_lines >= 2 && b >= 2) begin
        win[0] = cols[0];
        win[1] = cols[1];
        win[2] = o;
        win[3] = cols[2];
        win[4] = cols[3];
        win[5] = p;
        win[6] = cols[4];
        win[7] = cols[5];
        win[8] = s;
        w.bin_index    = BIN_W'(b - 1);
        w.line_index   = line_pos - 1'b1;
        w.median_value = median9(win);
        expected_medians = {expected_medians, w};
      end
      older_line[b]    = p;
      previous_line[b] = s;
      cols[0] = cols[1];
      cols[1] = o;
      cols[2] = cols[3];
      cols[3] = p;
      cols[4] = cols[5];
      cols[5] = s;
      bin_pos = b + 1;
      if (bin_pos >= len) next_line();
    endfunction

    // Compare one accepted median word with the oldest expected one, field by field.
    function void compare_median(out_word_t got);
      out_word_t want;
      if (expected_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 200) begin
          $display("%0t: median word with none expected: expected nothing, actual %h",
                   $time, got);
        end
      end else begin
        want = expected_medians.pop_front();
        if (got.bin_index !== want.bin_index) begin
          mismatches++;
          if (mismatches <= 200) begin
            $display("%0t: bin_index expected %0d, actual %0d",
                     $time, want.bin_index, got.bin_index);
          end
        end
        if (got.line_index !== want.line_index) begin
          mismatches++;
          if (mismatches <= 200) begin
            $display("%0t: line_index expected %0d, actual %0d",
                     $time, want.line_index, got.line_index);
          end
        end
        if (got.median_value !== want.median_value) begin
          mismatches++;
          if (mismatches <= 200) begin
            $display("%0t: median_value expected %0d, actual %0d",
                     $time, want.median_value, got.median_value);
          end
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_median_filter_3x3_top.sv =====
// Testbench top for the 3x3 median filter: drives sample words and checks every median word.
`timescale 1ns / 100ps
module tb_median_filter_3x3_top;
  import mf3_pkg::*;
  import mf3_tb_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_WORDS  = 220;
  localparam logic [0:20] DIRECTED_FS = 21'b1_000000000000000_1_0000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_write;
  logic [CFG_W-1:0] cfg_data;

  mf3_in_if  pix_if ();
  mf3_out_if med_if ();

  median_filter_3x3_top u_top (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_if),
    .medians   (med_if),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  median_tracker tracker;
  sample_t       directed_words [21];
  int            burst_left;
  int            max_burst;
  int            max_gap;
  bit            calm;
  bit            hold_request;

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: a rotating stall pattern that is re-drawn at random, and one long hold on request.
  initial begin : receiver
    logic [31:0] pattern;
    int          tick;
    pattern       = '1;
    tick          = 0;
    med_if.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        med_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 3))
          0:       pattern = '1;
          1:       pattern = $urandom;
          2:       pattern = $urandom | $urandom;
          default: pattern = $urandom & $urandom;
        endcase
      end
      med_if.ready <= pattern[0];
      pattern = {pattern[0], pattern[31:1]};
      tick++;
    end
  end

  // Every accepted median word goes to the tracker.
  always @(posedge clk) begin
    if (!rst && med_if.valid === 1'b1 && med_if.ready === 1'b1) begin
      tracker.compare_median(med_if.data);
    end
  end

  task automatic write_length(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    tracker.set_length(v);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Offer one sample word, opening a gap first when the current burst is used up.
  task automatic send_word(input sample_t s, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, max_burst);
      gap = calm ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        @(negedge clk);
        pix_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    pix_if.valid <= 1'b1;
    pix_if.data  <= '{sample: s, frame_start: fs};
    do @(posedge clk); while (pix_if.ready !== 1'b1);
    tracker.take_sample(s, fs);
  endtask

  // Stop sending and wait until every expected median word has come, then let the pipeline settle.
  task automatic wait_for_medians();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (tracker.expected_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random sample words, weighted towards the extremes and towards ties.
  task automatic run_random(input int count, input logic first_fs, input int fs_odds,
                            input int hold_at);
    int      k;
    logic    fs;
    sample_t s;
    for (k = 0; k < count; k++) begin
      if (k == 0) begin
        fs = first_fs;
      end else begin
        fs = (fs_odds != 0) && ($urandom_range(1, fs_odds) == 1);
      end
      case ($urandom_range(0, 7))
        0:       s = '0;
        1:       s = '1;
        2:       s = sample_t'($urandom_range(0, 3));
        default: s = sample_t'($urandom);
      endcase
      if (k == hold_at) hold_request = 1'b1;
      send_word(s, fs);
    end
  endtask

  initial begin : stimulus
    int   k;
    int   cfg_val;
    int   prev_len;
    int   phase_len;
    int   count;
    int   rnd_words;
    logic first_fs;
    tracker        = new();
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_data       = '0;
    pix_if.valid   = 1'b0;
    pix_if.data    = '0;
    hold_request   = 1'b0;
    burst_left     = 0;
    max_burst      = 16;
    max_gap        = 6;
    calm           = 1'b0;
    directed_words = '{16'hFFFF, 16'h0000, 16'hFFFF,
                       16'h0000, 16'hFFFF, 16'h0000,
                       16'hFFFF, 16'hFFFF, 16'h0000,
                       16'h0000, 16'h0000, 16'h0000,
                       16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // No frame start at all: the stream counts from reset at the reset length.
    run_random(40, 1'b0, 0, -1);
    wait_for_medians();

    // Still no frame start: a short length closes the long line with the next word.
    write_length(CFG_W'(4));
    run_random(40, 1'b0, 0, -1);
    wait_for_medians();

    // Directed words on three-bin lines, with a frame restart in mid-line.
    write_length(CFG_W'(MIN_LINE));
    for (k = 0; k < 21; k++) begin
      send_word(directed_words[k], DIRECTED_FS[k]);
    end
    wait_for_medians();

    // Stop at bin six of eight, then shorten the line so the next word closes it.
    write_length(CFG_W'(8));
    run_random(30, 1'b1, 0, -1);
    wait_for_medians();
    write_length(CFG_W'(4));
    run_random(30, 1'b0, 0, -1);
    wait_for_medians();

    // Long hold on the result side while words keep coming, so the input stalls.
    write_length(CFG_W'(MIN_LINE));
    run_random(100, 1'b1, 0, 20);
    wait_for_medians();

    // Random phases of short lines; a longer line always starts a new frame.
    rnd_words = 0;
    while (rnd_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 7))
        0:       cfg_val = $urandom_range(0, 2);
        1:       cfg_val = $urandom_range(11, 20);
        default: cfg_val = $urandom_range(3, 10);
      endcase
      prev_len = tracker.active_length();
      write_length(CFG_W'(cfg_val));
      phase_len = tracker.active_length();
      first_fs  = (phase_len > prev_len) || ($urandom_range(0, 1) == 1);
      count     = phase_len * $urandom_range(3, 6) + $urandom_range(0, phase_len - 1);
      calm      = ($urandom_range(0, 3) == 0);
      run_random(count, first_fs, ($urandom_range(0, 3) == 0) ? 40 : 0, -1);
      rnd_words += count;
      wait_for_medians();
    end

    // A written length with every bit set is held at the store depth; a short frame emits nothing.
    write_length('1);
    run_random(20, 1'b1, 0, -1);
    wait_for_medians();

    if (tracker.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Time limit for the whole run.
  initial begin : watchdog
    #(400_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mf3_pkg.sv
src/mf3_in_if.sv
src/mf3_out_if.sv
src/mf3_ram.sv
src/mf3_front.sv
src/mf3_median.sv
src/median_filter_3x3_top.sv
src/mf3_checker.sv
tb/mf3_tb_pkg.sv
tb/tb_median_filter_3x3_top.sv
